### src/bfp_pkg.sv
// ----------------------------------------------------------------------------
// bfp_pkg
// Types, codes and helpers shared by the byte frame parser.
// ----------------------------------------------------------------------------
package bfp_pkg;

  localparam int unsigned AddrW   = 5;

  typedef enum logic [2:0] {
    REG_FRAME_ID_NORMAL = 3'd0,
    REG_FRAME_ID_DEBUG  = 3'd1,
    REG_FRAME_ID_UPDATE = 3'd2,
    REG_EXP_FRAME_INDEX = 3'd3,
    REG_EXP_PACKET_ID   = 3'd4
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_HUNT  = 3'd0,
    ST_INDEX = 3'd1,
    ST_PKTID = 3'd2,
    ST_CMD   = 3'd3,
    ST_LEN   = 3'd4,
    ST_DATA  = 3'd5,
    ST_CSUM  = 3'd6
  } state_e;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_BAD     = 2'd2
  } kind_e;

  typedef struct packed {
    logic [7:0] frame_id_normal;
    logic [7:0] frame_id_debug;
    logic [7:0] frame_id_update;
    logic [7:0] exp_frame_index;
    logic [7:0] exp_packet_id;
  } cfg_t;

  typedef struct packed {
    logic [7:0] computed_checksum;
    logic [7:0] received_checksum;
    logic [7:0] payload_index;
    logic [7:0] payload_byte;
    logic [7:0] payload_length;
    logic [7:0] command;
    logic [7:0] frame_id;
  } result_t;

  // 8-bit end-around add: wrap the carry back into bit 0
  function automatic logic [7:0] sum_add(input logic [7:0] s, input logic [7:0] b);
    logic [8:0] t;
    t = {1'b0, s} + {1'b0, b};
    return t[8] ? (t[7:0] + 8'd1) : t[7:0];
  endfunction

endpackage

### src/bfp_regs.sv
// ----------------------------------------------------------------------------
// bfp_regs
// APB register file holding the accepted frame ids and expected header bytes.
// ----------------------------------------------------------------------------
module bfp_regs
  import bfp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[AddrW-1:2];
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_FRAME_ID_NORMAL: cfg_d.frame_id_normal = pwdata[7:0];
        REG_FRAME_ID_DEBUG:  cfg_d.frame_id_debug  = pwdata[7:0];
        REG_FRAME_ID_UPDATE: cfg_d.frame_id_update = pwdata[7:0];
        REG_EXP_FRAME_INDEX: cfg_d.exp_frame_index = pwdata[7:0];
        REG_EXP_PACKET_ID:   cfg_d.exp_packet_id   = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FRAME_ID_NORMAL: prdata = {24'd0, cfg_q.frame_id_normal};
      REG_FRAME_ID_DEBUG:  prdata = {24'd0, cfg_q.frame_id_debug};
      REG_FRAME_ID_UPDATE: prdata = {24'd0, cfg_q.frame_id_update};
      REG_EXP_FRAME_INDEX: prdata = {24'd0, cfg_q.exp_frame_index};
      REG_EXP_PACKET_ID:   prdata = {24'd0, cfg_q.exp_packet_id};
      default:             prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### src/byte_frame_parser_checksum.sv
// ----------------------------------------------------------------------------
// byte_frame_parser_checksum
// Hunts for id/index/packet/command/length/payload/checksum frames in a byte
// stream, passes payload bytes out and flags each frame end good or bad.
//
//   channel  dir  payload
//   s_axis   in   tdata[7:0] rx_byte
//   m_axis   out  tdata payload fields, tuser kind, tlast frame end
//   apb      in   five 8-bit registers at byte address 4*i
//
// One beat per cycle in, at most one beat per cycle out. State update and
// result are formed combinationally; the result lands in an output register.
// Input is stalled only while that register is full and not being taken.
// Reset clears parser state, output valid and the config registers to zero.
// ----------------------------------------------------------------------------
module byte_frame_parser_checksum
  import bfp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,   // [7:0] rx_byte
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // [7:0] frame_id, [15:8] command, [23:16] payload_length, [31:24] payload_byte,
  // [39:32] payload_index, [47:40] received_checksum, [55:48] computed_checksum
  output logic [55:0]      m_axis_tdata,
  output logic [1:0]       m_axis_tuser,   // [1:0] kind
  output logic             m_axis_tlast,   // frame_last
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t cfg;

  bfp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  state_e     state_q, state_d;
  logic [7:0] fid_q, fid_d;
  logic [7:0] cmd_q, cmd_d;
  logic [7:0] len_q, len_d;
  logic [7:0] cnt_q, cnt_d;
  logic [7:0] sum_q, sum_d;

  logic       out_valid_q, out_valid_d;
  result_t    res_q, res_d;
  kind_e      kind_q, kind_d;
  logic       last_q, last_d;

  logic       accept;
  logic       has_res;
  logic [7:0] b;
  logic [7:0] sum_next;
  logic [7:0] cnt_inc;
  logic       id_hit;

  assign b        = s_axis_tdata;
  assign accept   = s_axis_tvalid & s_axis_tready;
  assign s_axis_tready = ~out_valid_q | m_axis_tready;
  assign sum_next = sum_add(sum_q, b);
  assign cnt_inc  = cnt_q + 8'd1;
  assign id_hit   = (b == cfg.frame_id_normal) | (b == cfg.frame_id_debug) |
                    (b == cfg.frame_id_update);

  // next state
  always_comb begin
    state_d = state_q;
    if (accept) begin
      unique case (state_q)
        ST_INDEX: state_d = (b == cfg.exp_frame_index) ? ST_PKTID : ST_HUNT;
        ST_PKTID: state_d = (b == cfg.exp_packet_id) ? ST_CMD : ST_HUNT;
        ST_CMD:   state_d = ST_LEN;
        ST_LEN:   state_d = (b == 8'd0) ? ST_CSUM : ST_DATA;
        ST_DATA:  state_d = (cnt_inc == len_q) ? ST_CSUM : ST_DATA;
        ST_CSUM:  state_d = ST_HUNT;
        default:  state_d = id_hit ? ST_INDEX : ST_HUNT;
      endcase
    end
  end

  // datapath and result
  always_comb begin
    fid_d   = fid_q;
    cmd_d   = cmd_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    sum_d   = sum_q;
    has_res = 1'b0;
    kind_d  = KIND_PAYLOAD;
    last_d  = 1'b0;
    res_d   = '0;
    res_d.frame_id       = fid_q;
    res_d.command        = cmd_q;
    res_d.payload_length = len_q;
    unique case (state_q) inside
      ST_INDEX, ST_PKTID: sum_d = sum_next;
      ST_CMD: begin
        sum_d = sum_next;
        cmd_d = b;
      end
      ST_LEN: begin
        sum_d = sum_next;
        len_d = b;
        cnt_d = 8'd0;
      end
      ST_DATA: begin
        sum_d   = sum_next;
        cnt_d   = cnt_inc;
        has_res = 1'b1;
        res_d.payload_byte  = b;
        res_d.payload_index = cnt_q;
      end
      ST_CSUM: begin
        has_res = 1'b1;
        kind_d  = (b == sum_q) ? KIND_GOOD : KIND_BAD;
        last_d  = 1'b1;
        res_d.received_checksum = b;
        res_d.computed_checksum = sum_q;
      end
      default: begin
        fid_d = b;
        cmd_d = 8'd0;
        len_d = 8'd0;
        cnt_d = 8'd0;
        sum_d = sum_add(8'd0, b);
      end
    endcase
  end

  always_comb begin
    if (accept && has_res) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_HUNT;
      fid_q       <= '0;
      cmd_q       <= '0;
      len_q       <= '0;
      cnt_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (accept) begin
        fid_q <= fid_d;
        cmd_q <= cmd_d;
        len_q <= len_d;
        cnt_q <= cnt_d;
        sum_q <= sum_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && has_res) begin
      res_q  <= res_d;
      kind_q <= kind_d;
      last_q <= last_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = res_q;
  assign m_axis_tuser  = kind_q;
  assign m_axis_tlast  = last_q;

endmodule
